### design/mat4inv_pkg.sv
`default_nettype none

package mat4inv_pkg;

    localparam int ELEM_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    localparam logic [2:0] TERM_LAST = 3'd5;

    typedef enum logic [4:0] {
        S_LOAD,
        S_TA,
        S_TB,
        S_TC,
        S_TD,
        S_M1,
        S_M2,
        S_ACC,
        S_WCOF,
        S_DA,
        S_DB,
        S_M3,
        S_DACC,
        S_DFIN,
        S_OA,
        S_OB,
        S_DIV,
        S_SAT,
        S_OUT
    } state_t;

    // Column order of each of the six products of a 3x3 determinant.
    function automatic logic [1:0] perm_col(input logic [2:0] t, input logic [1:0] j);
        logic [5:0] p;
        unique case (t)
            3'd0:    p = {2'd2, 2'd1, 2'd0};
            3'd1:    p = {2'd1, 2'd2, 2'd0};
            3'd2:    p = {2'd2, 2'd0, 2'd1};
            3'd3:    p = {2'd0, 2'd2, 2'd1};
            3'd4:    p = {2'd1, 2'd0, 2'd2};
            3'd5:    p = {2'd0, 2'd1, 2'd2};
            default: p = '0;
        endcase
        unique case (j)
            2'd0:    return p[1:0];
            2'd1:    return p[3:2];
            default: return p[5:4];
        endcase
    endfunction

    function automatic logic term_neg(input logic [2:0] t);
        return (t == 3'd1) || (t == 3'd2) || (t == 3'd5);
    endfunction

    // Store address of element j of product t of the minor that belongs to adjugate entry k.
    function automatic logic [3:0] minor_addr(input logic [3:0] k, input logic [2:0] t,
                                              input logic [1:0] j);
        logic [1:0] row;
        logic [1:0] pc;
        logic [1:0] col;
        row = (j < k[1:0]) ? j : j + 2'd1;
        pc  = perm_col(t, j);
        col = (pc < k[3:2]) ? pc : pc + 2'd1;
        return {row, col};
    endfunction

endpackage

`default_nettype wire

### design/mat4inv_if.sv
`default_nettype none

interface mat4inv_in_if
    import mat4inv_pkg::*;
#(
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [ELEM_WIDTH-1:0] element_in;

    modport source (output valid, output element_in, input ready);
    modport sink   (input valid, input element_in, output ready);
endinterface

interface mat4inv_out_if
    import mat4inv_pkg::*;
#(
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [ELEM_WIDTH-1:0] element_out;
    logic [3:0]                   position;
    logic                         singular;
    logic                         saturated;
    logic                         last;

    modport source (output valid, output element_out, output position, output singular,
                    output saturated, output last, input ready);
    modport sink   (input valid, input element_out, input position, input singular,
                    input saturated, input last, output ready);
endinterface

`default_nettype wire

### design/matrix4_inverse_adjugate.sv
// Takes sixteen element beats, one per cycle while the source holds valid, then works on the matrix alone.
// Cofactors: six triple products each, all on one serial multiplier.
// Determinant: four products on the same multiplier; each result beat then goes through the
// restoring divider, unless the matrix is singular. Input is refused meanwhile.
// Reset (rst_n low, asynchronous) empties the load count and idles the sequencer;
// the element and cofactor memories keep their contents.
`default_nettype none

module matrix4_inverse_adjugate
    import mat4inv_pkg::*;
#(
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    mat4inv_in_if.sink     in_ch,
    mat4inv_out_if.source  out_ch
);

    localparam int W    = ELEM_WIDTH;
    localparam int CW   = 3 * W + 3;
    localparam int DW   = 4 * W + 5;
    localparam int NW   = CW + 2 * FRAC_BITS;
    localparam int RW   = DW + 1;
    localparam int CNTW = $clog2(NW + 1);

    state_t state_reg;
    state_t state_next;

    logic [3:0]      load_cnt_reg;
    logic [3:0]      k_reg;
    logic [2:0]      t_reg;
    logic [1:0]      j_reg;
    logic [CNTW-1:0] cnt_reg;

    logic signed [W-1:0]  mat_mem [16];
    logic signed [W-1:0]  mat_rd_reg;
    logic [3:0]           mat_addr;
    logic signed [CW-1:0] cof_mem [16];
    logic signed [CW-1:0] cof_rd_reg;
    logic [3:0]           cof_addr;

    logic [W-1:0]         mplier_reg;
    logic signed [DW-1:0] mcand_reg;
    logic signed [DW-1:0] acc_reg;
    logic signed [DW-1:0] acc_next;
    logic signed [DW-1:0] addend;
    logic signed [W-1:0]  e3_reg;
    logic signed [CW-1:0] sum_reg;
    logic signed [DW-1:0] det_reg;
    logic [DW-1:0]        dmag_reg;
    logic                 dneg_reg;
    logic                 sing_reg;
    logic                 neg_reg;
    logic [NW-1:0]        num_reg;
    logic [RW-1:0]        rem_reg;
    logic [W:0]           q_reg;
    logic                 big_reg;
    logic signed [W-1:0]  out_elem_reg;
    logic                 out_sat_reg;

    logic          in_acc;
    logic          out_acc;
    logic          mul_last;
    logic          div_last;
    logic          flip;
    logic [CW-1:0] cmag;
    logic [RW-1:0] shifted;
    logic          ge;
    logic [W:0]    lim;
    logic          over;
    logic [W:0]    mag;

    assign in_acc   = in_ch.valid && in_ch.ready;
    assign out_acc  = out_ch.valid && out_ch.ready;
    assign mul_last = (cnt_reg == CNTW'(W - 1));
    assign div_last = (cnt_reg == CNTW'(NW - 1));
    assign flip     = term_neg(t_reg) ^ k_reg[0] ^ k_reg[2];

    assign addend   = mplier_reg[W-1] ? ((cnt_reg == '0) ? -mcand_reg : mcand_reg) : '0;
    assign acc_next = ((cnt_reg == '0) ? DW'(0) : (acc_reg <<< 1)) + addend;

    assign cmag    = cof_rd_reg[CW-1] ? CW'(-cof_rd_reg) : CW'(cof_rd_reg);
    assign shifted = {rem_reg[RW-2:0], num_reg[NW-1]};
    assign ge      = (shifted >= {1'b0, dmag_reg});
    assign lim     = ((W + 1)'(1) << (W - 1)) - {{W{1'b0}}, ~neg_reg};
    assign over    = big_reg || (q_reg > lim);
    assign mag     = over ? lim : q_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_LOAD: if (in_acc && load_cnt_reg == 4'hF) state_next = S_TA;
            S_TA:   state_next = S_TB;
            S_TB:   state_next = S_TC;
            S_TC:   state_next = S_TD;
            S_TD:   state_next = S_M1;
            S_M1:   if (mul_last) state_next = S_M2;
            S_M2:   if (mul_last) state_next = S_ACC;
            S_ACC:  state_next = (t_reg == TERM_LAST) ? S_WCOF : S_TA;
            S_WCOF: state_next = (k_reg == 4'hF) ? S_DA : S_TA;
            S_DA:   state_next = S_DB;
            S_DB:   state_next = S_M3;
            S_M3:   if (mul_last) state_next = S_DACC;
            S_DACC: state_next = (j_reg == 2'd3) ? S_DFIN : S_DA;
            S_DFIN: state_next = S_OA;
            S_OA:   state_next = S_OB;
            S_OB:   state_next = sing_reg ? S_OUT : S_DIV;
            S_DIV:  if (div_last) state_next = S_SAT;
            S_SAT:  state_next = S_OUT;
            S_OUT:  if (out_acc) state_next = (k_reg == 4'hF) ? S_LOAD : S_OA;
            default: state_next = S_LOAD;
        endcase
    end

    always_comb
    begin
        in_ch.ready  = (state_reg == S_LOAD);
        out_ch.valid = (state_reg == S_OUT);
        mat_addr     = k_reg;
        cof_addr     = k_reg;
        unique case (state_reg)
            S_TA:    mat_addr = minor_addr(k_reg, t_reg, 2'd0);
            S_TB:    mat_addr = minor_addr(k_reg, t_reg, 2'd1);
            S_TC:    mat_addr = minor_addr(k_reg, t_reg, 2'd2);
            S_DA:
            begin
                mat_addr = {2'b00, j_reg};
                cof_addr = {j_reg, 2'b00};
            end
            default: ;
        endcase
    end

    assign out_ch.element_out = out_elem_reg;
    assign out_ch.position    = k_reg;
    assign out_ch.singular    = sing_reg;
    assign out_ch.saturated   = out_sat_reg;
    assign out_ch.last        = (k_reg == 4'hF);

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            mat_mem[load_cnt_reg] <= in_ch.element_in;
        end
        mat_rd_reg <= mat_mem[mat_addr];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_WCOF)
        begin
            cof_mem[k_reg] <= sum_reg;
        end
        cof_rd_reg <= cof_mem[cof_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_LOAD;
            load_cnt_reg <= '0;
            k_reg        <= '0;
            t_reg        <= '0;
            j_reg        <= '0;
            cnt_reg      <= '0;
            sing_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                S_LOAD:
                begin
                    if (in_acc)
                    begin
                        load_cnt_reg <= load_cnt_reg + 4'd1;
                        k_reg        <= '0;
                        t_reg        <= '0;
                        j_reg        <= '0;
                    end
                end
                S_TD:   cnt_reg <= '0;
                S_M1, S_M2, S_M3:
                begin
                    cnt_reg <= mul_last ? '0 : cnt_reg + CNTW'(1);
                end
                S_ACC:  t_reg <= (t_reg == TERM_LAST) ? 3'd0 : t_reg + 3'd1;
                S_WCOF: k_reg <= k_reg + 4'd1;
                S_DB:   cnt_reg <= '0;
                S_DACC: j_reg <= j_reg + 2'd1;
                S_DFIN:
                begin
                    sing_reg <= (det_reg == '0);
                    k_reg    <= '0;
                end
                S_OB:   cnt_reg <= '0;
                S_DIV:  cnt_reg <= cnt_reg + CNTW'(1);
                S_OUT:  if (out_acc) k_reg <= k_reg + 4'd1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_LOAD:
            begin
                sum_reg <= '0;
                det_reg <= '0;
            end
            S_TB: mplier_reg <= mat_rd_reg;
            S_TC: mcand_reg <= DW'(mat_rd_reg);
            S_TD: e3_reg <= mat_rd_reg;
            S_M1:
            begin
                acc_reg <= acc_next;
                if (mul_last)
                begin
                    mplier_reg <= e3_reg;
                    mcand_reg  <= acc_next;
                end
                else
                begin
                    mplier_reg <= mplier_reg << 1;
                end
            end
            S_M2, S_M3:
            begin
                acc_reg    <= acc_next;
                mplier_reg <= mplier_reg << 1;
            end
            S_ACC:  sum_reg <= flip ? sum_reg - acc_reg[CW-1:0] : sum_reg + acc_reg[CW-1:0];
            S_WCOF: sum_reg <= '0;
            S_DB:
            begin
                mplier_reg <= mat_rd_reg;
                mcand_reg  <= DW'(cof_rd_reg);
            end
            S_DACC: det_reg <= det_reg + acc_reg;
            S_DFIN:
            begin
                dneg_reg <= det_reg[DW-1];
                dmag_reg <= det_reg[DW-1] ? DW'(-det_reg) : DW'(det_reg);
            end
            S_OB:
            begin
                out_elem_reg <= mat_rd_reg;
                out_sat_reg  <= 1'b0;
                neg_reg      <= cof_rd_reg[CW-1] ^ dneg_reg;
                num_reg      <= NW'(cmag) << (2 * FRAC_BITS);
                rem_reg      <= '0;
                q_reg        <= '0;
                big_reg      <= 1'b0;
            end
            S_DIV:
            begin
                rem_reg <= ge ? shifted - {1'b0, dmag_reg} : shifted;
                q_reg   <= {q_reg[W-1:0], ge};
                big_reg <= big_reg | q_reg[W];
                num_reg <= num_reg << 1;
            end
            S_SAT:
            begin
                out_elem_reg <= neg_reg ? -mag[W-1:0] : mag[W-1:0];
                out_sat_reg  <= over;
            end
            default: ;
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> !in_ch.ready)
        else $error("result offered while input is open");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.singular |-> !out_ch.saturated)
        else $error("singular beat flagged as saturated");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.last == (out_ch.position == 4'hF)))
        else $error("last flag does not match position");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.ready && out_ch.last |=> in_ch.ready && load_cnt_reg == 4'd0)
        else $error("block not ready for a new matrix after the final beat");

endmodule

`default_nettype wire

### verif/matrix4_inverse_checker.sv
`default_nettype none

module matrix4_inverse_checker
    import mat4inv_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    mat4inv_in_if     in_ch,
    mat4inv_out_if    out_ch,
    output int        fail_count,
    output int        pending,
    output int        singular_seen,
    output int        saturated_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [255:0] wide_t;

    typedef struct packed {
        logic signed [31:0] element;
        logic [3:0]         position;
        logic               singular;
        logic               saturated;
        logic               last;
    } inverse_beat_t;

    logic signed [31:0] elements [0:15];
    wide_t              exact [0:15];
    logic [3:0]         fill;
    inverse_beat_t      inverse_q [$];

    function automatic wide_t cofactor3(input int skip_row, input int skip_col);
        wide_t a [0:8];
        int    n;
        n = 0;
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                if (r != skip_row && c != skip_col)
                begin
                    a[n] = exact[r * 4 + c];
                    n++;
                end
        return a[0] * (a[4] * a[8] - a[5] * a[7])
             - a[1] * (a[3] * a[8] - a[5] * a[6])
             + a[2] * (a[3] * a[7] - a[4] * a[6]);
    endfunction

    task automatic predict_inverse();
        wide_t         det;
        wide_t         cof;
        wide_t         quot;
        inverse_beat_t beat;
        for (int k = 0; k < 16; k++)
            exact[k] = {{224{elements[k][31]}}, elements[k]};
        det = '0;
        for (int k = 0; k < 4; k++)
            if (k % 2 == 0)
                det = det + exact[k] * cofactor3(0, k);
            else
                det = det - exact[k] * cofactor3(0, k);
        for (int k = 0; k < 16; k++)
        begin
            beat.position  = 4'(k);
            beat.last      = (k == 15);
            beat.singular  = (det == 0);
            beat.saturated = 1'b0;
            if (det == 0)
                beat.element = elements[k];
            else
            begin
                cof = cofactor3(k % 4, k / 4);
                if (((k / 4) + (k % 4)) % 2 == 1)
                    cof = -cof;
                quot = (cof <<< 32) / det;
                if (quot > 256'sh7fffffff)
                begin
                    beat.element   = 32'sh7fffffff;
                    beat.saturated = 1'b1;
                end
                else if (quot < -256'sh80000000)
                begin
                    beat.element   = 32'sh80000000;
                    beat.saturated = 1'b1;
                end
                else
                    beat.element = quot[31:0];
            end
            inverse_q.push_back(beat);
        end
    endtask

    always @(posedge clk)
    begin
        inverse_beat_t want;
        if (!rst_n)
        begin
            fill           <= '0;
            fail_count     <= 0;
            singular_seen  <= 0;
            saturated_seen <= 0;
            inverse_q.delete();
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                elements[fill] = in_ch.element_in;
                fill <= fill + 4'd1;
                if (fill == 4'd15)
                    predict_inverse();
            end
            if (out_ch.valid && out_ch.ready)
            begin
                if (inverse_q.size() == 0)
                begin
                    $display("%0t: unexpected beat element=%h position=%0d", $time,
                             out_ch.element_out, out_ch.position);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = inverse_q.pop_front();
                    if (out_ch.element_out !== want.element || out_ch.position !== want.position
                        || out_ch.singular !== want.singular
                        || out_ch.saturated !== want.saturated || out_ch.last !== want.last)
                    begin
                        $display("%0t: expected element=%h pos=%0d sing=%b sat=%b last=%b",
                                 $time, want.element, want.position, want.singular,
                                 want.saturated, want.last);
                        $display("%0t: actual   element=%h pos=%0d sing=%b sat=%b last=%b",
                                 $time, out_ch.element_out, out_ch.position, out_ch.singular,
                                 out_ch.saturated, out_ch.last);
                        fail_count <= fail_count + 1;
                    end
                    if (want.singular && want.last)
                        singular_seen <= singular_seen + 1;
                    if (want.saturated)
                        saturated_seen <= saturated_seen + 1;
                end
            end
        end
    end

    assign pending = inverse_q.size();

endmodule

`default_nettype wire

### verif/testbench.sv
`default_nettype none

module testbench;
    import mat4inv_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MATRICES   = 16;
    localparam int CALM_FROM  = 13;
    localparam int LONG_HOLD  = 3000;
    localparam int WATCHDOG   = 40000;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   singular_seen;
    int   saturated_seen;
    bit   bursty;
    bit   hold_request;
    bit   hold_done;
    int   hold_left;
    int   quiet_cycles;
    logic signed [31:0] mat [0:15];

    mat4inv_in_if  in_ch ();
    mat4inv_out_if out_ch ();

    matrix4_inverse_adjugate i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    matrix4_inverse_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_ch          (in_ch),
        .out_ch         (out_ch),
        .fail_count     (fail_count),
        .pending        (pending),
        .singular_seen  (singular_seen),
        .saturated_seen (saturated_seen)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // The receiver stalls in short bursts, and once holds off long enough to back the block up.
    always @(negedge clk)
    begin
        if (hold_request && !hold_done)
        begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            out_ch.ready <= 1'b0;
            hold_left--;
        end
        else if (bursty && $urandom_range(0, 3) == 0)
        begin
            out_ch.ready <= 1'b0;
            hold_left = $urandom_range(0, 7);
        end
        else
            out_ch.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG)
        begin
            $display("%0t: no beat accepted for %0d cycles", $time, WATCHDOG);
            $display("[matrix4_inverse_adjugate] ERROR");
            $finish;
        end
    end

    task automatic send_element(input logic signed [31:0] value);
        if (bursty && $urandom_range(0, 3) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.element_in <= value;
        do
            @(posedge clk);
        while (!in_ch.ready);
        @(negedge clk);
    endtask

    function automatic logic signed [31:0] near_unit();
        return $urandom_range(0, 262143) - 131072;
    endfunction

    task automatic make_matrix(input int kind);
        for (int k = 0; k < 16; k++)
            case (kind)
                0:       mat[k] = $urandom;
                1, 2, 3: mat[k] = near_unit();
                4:       mat[k] = (k % 5 == 0) ? (($urandom_range(1, 8) << 16)
                                  * ($urandom_range(0, 1) ? 1 : -1)) : near_unit() >>> 4;
                default: mat[k] = $urandom_range(0, 6) - 3;
            endcase
        if (kind == 2)
            for (int c = 0; c < 4; c++)
                mat[12 + c] = mat[4 + c];
        if (kind == 3)
        begin
            int col;
            col = $urandom_range(0, 3);
            for (int r = 0; r < 4; r++)
                mat[r * 4 + col] = '0;
        end
    endtask

    initial
    begin
        rst_n            = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.element_in = '0;
        out_ch.ready     = 1'b0;
        bursty           = 1'b1;
        hold_request     = 1'b0;
        hold_done        = 1'b0;
        hold_left        = 0;
        quiet_cycles     = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Upper triangular with unit-raw diagonal of mixed sign and extreme off-diagonal
        // entries: the determinant is tiny, so inverse entries clip both ways.
        for (int k = 0; k < 16; k++)
            mat[k] = (k % 5 == 0) ? 32'sd1 : ((k % 4 > k / 4) ? near_unit() : '0);
        mat[5] = -32'sd1;
        mat[1] = 32'sh7fffffff;
        mat[2] = 32'sh80000000;
        mat[3] = 32'shffffffff;
        for (int k = 0; k < 16; k++)
            send_element(mat[k]);

        for (int n = 1; n < MATRICES; n++)
        begin
            if (n == 3)
                hold_request = 1'b1;
            if (n >= CALM_FROM)
                bursty = 1'b0;
            if (n == 1)
                for (int k = 0; k < 16; k++)
                    mat[k] = '0;
            else
                make_matrix($urandom_range(0, 5));
            for (int k = 0; k < 16; k++)
                send_element(mat[k]);
        end
        in_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (300) @(negedge clk);

        $display("Inverted %0d matrices under random stalls and one long output hold-off.",
                 MATRICES);
        $display("%0d came back singular and %0d elements were clipped.",
                 singular_seen, saturated_seen);
        if (fail_count == 0 && pending == 0)
            $display("[matrix4_inverse_adjugate] OK");
        else
            $display("[matrix4_inverse_adjugate] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
